// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the shortest-path engine.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;

    localparam int VTX_W  = 6;
    localparam int NV_W   = 7;
    localparam int WGT_W  = 16;
    localparam int DIST_W = 24;
    localparam int EA_W   = $clog2(MAX_EDGES);
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);

    localparam logic [NV_W-1:0] VC_RESET = NV_W'(MAX_VERTICES);

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_DIST  = 2'd0,
        ST_CYCLE = 2'd1,
        ST_OVFL  = 2'd2
    } status_t;

    typedef enum logic {
        CFG_VERTEX_COUNT  = 1'b0,
        CFG_SOURCE_VERTEX = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [VTX_W-1:0]        tail_vertex;
        logic [VTX_W-1:0]        head_vertex;
        logic signed [WGT_W-1:0] edge_weight;
        logic                    last_edge;
    } in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [VTX_W-1:0]         vertex_id;
        logic                     reachable;
        logic signed [DIST_W-1:0] path_length;
        logic                     last_result;
    } out_t;

    typedef struct packed {
        logic [VTX_W-1:0]        tail;
        logic [VTX_W-1:0]        head;
        logic signed [WGT_W-1:0] weight;
    } edge_t;

    // Command from front to back
    typedef struct packed {
        logic             store;
        logic [EA_W-1:0]  addr;
        edge_t            edge_data;
        logic             run;
        logic             ovf;
        logic [CNT_W-1:0] count;
    } cmd_t;

endpackage

// ===== rtl/ssp_front.sv =====
// ----------------------------------------------------------------------------
// ssp_front
// Accepts edge beats, assigns store slots, tracks overflow, issues commands.
// ----------------------------------------------------------------------------
module ssp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  ssp_pkg::in_t  item,
    input  logic          push,
    output logic          full,
    input  logic          q_full,
    output logic          q_push,
    output ssp_pkg::cmd_t q_data
);
    import ssp_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             room;

    assign full   = q_full;
    assign q_push = push && !q_full;
    assign room   = cnt_reg < CNT_W'(MAX_EDGES);

    always_comb
    begin
        q_data.store            = room;
        q_data.addr             = cnt_reg[EA_W-1:0];
        q_data.edge_data.tail   = item.tail_vertex;
        q_data.edge_data.head   = item.head_vertex;
        q_data.edge_data.weight = item.edge_weight;
        q_data.run              = item.last_edge;
        q_data.ovf              = ovf_reg || !room;
        q_data.count            = room ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (q_push)
        begin
            if (item.last_edge)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else if (room)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// ===== rtl/ssp_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// ssp_cmd_queue
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ssp_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  ssp_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd,
    output ssp_pkg::cmd_t rd_data,
    output logic          empty
);
    import ssp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;

    assign full    = cnt_reg == (PW+1)'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + PW'(1);
            end
            if (rd)
            begin
                rp_reg <= rp_reg + PW'(1);
            end
            cnt_reg <= cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end

endmodule

// ===== rtl/ssp_back.sv =====
// ----------------------------------------------------------------------------
// ssp_back
// Edge store, relaxation sequencer, distance table and result queue.
// ----------------------------------------------------------------------------
module ssp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ssp_pkg::cmd_t           q_data,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  logic [ssp_pkg::NV_W-1:0]  vertex_count,
    input  logic [ssp_pkg::VTX_W-1:0] source_vertex,
    output ssp_pkg::out_t           result,
    output logic                    empty,
    input  logic                    pop
);
    import ssp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INIT    = 8'b0000_0010,
        S_RD_EDGE = 8'b0000_0100,
        S_RD_DIST = 8'b0000_1000,
        S_EXEC    = 8'b0001_0000,
        S_EMIT_RD = 8'b0010_0000,
        S_EMIT_WR = 8'b0100_0000,
        S_SINGLE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // storage
    edge_t                    edge_mem [MAX_EDGES];
    logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  valid_reg, valid_next;

    // run control
    logic [CNT_W-1:0] ecnt_reg, ecnt_next;
    logic [NV_W-1:0]  n_reg, n_next;
    logic [EA_W-1:0]  eidx_reg, eidx_next;
    logic [VTX_W-1:0] pass_reg, pass_next;
    logic [VTX_W-1:0] v_reg, v_next;
    logic [1:0]       single_reg, single_next;

    // read data
    edge_t                    edge_q;
    logic signed [DIST_W-1:0] dt_q, dh_q;
    logic                     vt_q, vh_q;
    logic [VTX_W-1:0]         rda_addr;

    // dist write port
    logic                     dw_en;
    logic [VTX_W-1:0]         dw_addr;
    logic signed [DIST_W-1:0] dw_data;

    // result queue
    out_t oq_reg [2];
    logic oq_wp_reg, oq_rp_reg;
    logic [1:0] oq_cnt_reg;
    logic oq_full, oq_push;
    out_t oq_in;

    logic [NV_W-1:0]          n_eff;
    logic                     in_range, last_pass, last_edge_idx;
    logic signed [DIST_W:0]   cand;
    logic signed [DIST_W-1:0] cand_sat;
    logic                     improve_relax, improve_check;

    assign n_eff = (vertex_count == '0) ? NV_W'(1) :
                   (vertex_count > NV_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : vertex_count;

    assign in_range = ({1'b0, edge_q.tail} < n_reg) && ({1'b0, edge_q.head} < n_reg) && vt_q;
    assign last_pass     = {1'b0, pass_reg} == n_reg - NV_W'(1);
    assign last_edge_idx = {1'b0, eidx_reg} == ecnt_reg - CNT_W'(1);

    assign cand = {dt_q[DIST_W-1], dt_q}
                + {{(DIST_W+1-WGT_W){edge_q.weight[WGT_W-1]}}, edge_q.weight};
    assign cand_sat = (cand[DIST_W] != cand[DIST_W-1])
                    ? (cand[DIST_W] ? DIST_MIN : DIST_MAX) : cand[DIST_W-1:0];

    assign improve_relax = !vh_q || (cand_sat < dh_q);
    assign improve_check = !vh_q || (cand < $signed({dh_q[DIST_W-1], dh_q}));

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign rda_addr = (state_reg == S_EMIT_RD) ? v_reg : edge_q.tail;

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = valid_reg;
        ecnt_next   = ecnt_reg;
        n_next      = n_reg;
        eidx_next   = eidx_reg;
        pass_next   = pass_reg;
        v_next      = v_reg;
        single_next = single_reg;
        dw_en       = 1'b0;
        dw_addr     = edge_q.head;
        dw_data     = cand_sat;
        oq_push     = 1'b0;
        oq_in       = '0;
        oq_in.last_result = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && q_data.run)
                begin
                    if (q_data.ovf)
                    begin
                        single_next = ST_OVFL;
                        state_next  = S_SINGLE;
                    end
                    else
                    begin
                        ecnt_next  = q_data.count;
                        n_next     = n_eff;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                valid_next = '0;
                if ({1'b0, source_vertex} < n_reg)
                begin
                    valid_next[source_vertex] = 1'b1;
                end
                dw_en     = 1'b1;
                dw_addr   = source_vertex;
                dw_data   = '0;
                eidx_next = '0;
                pass_next = '0;
                v_next    = '0;
                state_next = (ecnt_reg == '0) ? S_EMIT_RD : S_RD_EDGE;
            end
            S_RD_EDGE:
            begin
                state_next = S_RD_DIST;
            end
            S_RD_DIST:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_RD_EDGE;
                if (last_pass && in_range && improve_check)
                begin
                    single_next = ST_CYCLE;
                    state_next  = S_SINGLE;
                end
                else
                begin
                    if (!last_pass && in_range && improve_relax)
                    begin
                        dw_en = 1'b1;
                        valid_next[edge_q.head] = 1'b1;
                    end
                    if (last_edge_idx)
                    begin
                        eidx_next = '0;
                        if (last_pass)
                        begin
                            v_next     = '0;
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            pass_next = pass_reg + VTX_W'(1);
                        end
                    end
                    else
                    begin
                        eidx_next = eidx_reg + EA_W'(1);
                    end
                end
            end
            S_EMIT_RD:
            begin
                if (!oq_full)
                begin
                    state_next = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                oq_push           = 1'b1;
                oq_in.status      = ST_DIST;
                oq_in.vertex_id   = v_reg;
                oq_in.reachable   = vt_q;
                oq_in.path_length = vt_q ? dt_q : '0;
                oq_in.last_result = {1'b0, v_reg} == n_reg - NV_W'(1);
                if (oq_in.last_result)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    v_next     = v_reg + VTX_W'(1);
                    state_next = S_EMIT_RD;
                end
            end
            S_SINGLE:
            begin
                if (!oq_full)
                begin
                    oq_push      = 1'b1;
                    oq_in.status = single_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.store)
        begin
            edge_mem[q_data.addr] <= q_data.edge_data;
        end
        edge_q <= edge_mem[eidx_reg];
    end

    // distance table: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (dw_en)
        begin
            dist_mem[dw_addr] <= dw_data;
        end
        dt_q <= dist_mem[rda_addr];
        dh_q <= dist_mem[edge_q.head];
        vt_q <= valid_reg[rda_addr];
        vh_q <= valid_reg[edge_q.head];
    end

    // result queue
    assign oq_full = oq_cnt_reg == 2'd2;
    assign empty   = oq_cnt_reg == 2'd0;
    assign result  = oq_reg[oq_rp_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wp_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            ecnt_reg   <= '0;
            n_reg      <= NV_W'(1);
            eidx_reg   <= '0;
            pass_reg   <= '0;
            v_reg      <= '0;
            single_reg <= ST_OVFL;
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            ecnt_reg   <= ecnt_next;
            n_reg      <= n_next;
            eidx_reg   <= eidx_next;
            pass_reg   <= pass_next;
            v_reg      <= v_next;
            single_reg <= single_next;
            if (oq_push)
            begin
                oq_wp_reg <= !oq_wp_reg;
            end
            if (pop && !empty)
            begin
                oq_rp_reg <= !oq_rp_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + 2'(oq_push) - 2'(pop && !empty);
        end
    end

endmodule

// ===== rtl/single_source_shortest_paths.sv =====
// ----------------------------------------------------------------------------
// single_source_shortest_paths
// Bellman-Ford shortest paths over a streamed edge list.
// ----------------------------------------------------------------------------
// Edges are pushed one beat per cycle while full is low into a 256-entry
// edge store; the beat with last_edge set launches a run. A run has an init
// state, then each stored edge goes through the edge-read, distance-read and
// execute states, over (n-1) relaxation passes plus one check pass. Results
// then leave as n distance beats, each read from the distance table and then
// written to the result queue, or as one beat for a negative cycle or an
// overflowed edge store. Edges for the next graph are taken into a 4-entry
// command queue while a run is busy, and the front stalls (full) once it
// fills. Configuration (vertex_count, source_vertex) is sampled at run start
// and must be written while the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module single_source_shortest_paths (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ssp_pkg::in_t              item,
    input  logic                      push,
    output logic                      full,
    output ssp_pkg::out_t             result,
    output logic                      empty,
    input  logic                      pop,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [ssp_pkg::NV_W-1:0]  cfg_data
);
    import ssp_pkg::*;

    // configuration registers
    logic [NV_W-1:0]  vertex_count_reg;
    logic [VTX_W-1:0] source_vertex_reg;

    // front to queue
    cmd_t f_cmd;
    logic f_push;
    logic q_full;

    // queue to back
    cmd_t b_cmd;
    logic q_empty;
    logic b_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= VC_RESET;
            source_vertex_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data;
                CFG_SOURCE_VERTEX: source_vertex_reg <= cfg_data[VTX_W-1:0];
                default:           vertex_count_reg  <= vertex_count_reg;
            endcase
        end
    end

    // front: classifies each beat as store / drop and flags run launch
    ssp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .q_full (q_full),
        .q_push (f_push),
        .q_data (f_cmd)
    );

    // decoupling queue
    ssp_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_data (f_cmd),
        .full    (q_full),
        .rd      (b_pop),
        .rd_data (b_cmd),
        .empty   (q_empty)
    );

    // back: edge store, relaxation, result stream
    ssp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (b_cmd),
        .q_empty       (q_empty),
        .q_pop         (b_pop),
        .vertex_count  (vertex_count_reg),
        .source_vertex (source_vertex_reg),
        .result        (result),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

// ===== rtl/ssp_checker.sv =====
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the result stream.
// ----------------------------------------------------------------------------
module ssp_checker (
    input logic          clk,
    input logic          rst_n,
    input ssp_pkg::out_t result,
    input logic          empty,
    input logic          pop
);
    import ssp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status == ST_DIST || result.status == ST_CYCLE
                    || result.status == ST_OVFL))
        else $error("bad status code");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != ST_DIST) |->
        (result.last_result && !result.reachable && result.path_length == '0
         && result.vertex_id == '0))
        else $error("malformed cycle/overflow beat");

    a_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == ST_DIST && !result.reachable) |->
        (result.path_length == '0))
        else $error("unreachable vertex with nonzero length");

endmodule

bind single_source_shortest_paths ssp_checker u_ssp_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result),
    .empty  (empty),
    .pop    (pop)
);

// ===== test/tb_single_source_shortest_paths.sv =====
// ----------------------------------------------------------------------------
// tb_single_source_shortest_paths
// Self-checking bench for the streamed-edge shortest-path engine.
// ----------------------------------------------------------------------------
// A directed table covers the register extremes, negative cycles, saturation,
// out-of-range vertices and sources. Random graphs follow, plus a pressure
// phase where the result side holds off long enough to back up the input.
// Every result beat is checked field by field against an in-bench
// shortest-path predictor, or against a hand-written beat for typed rows.
// ----------------------------------------------------------------------------
module tb_single_source_shortest_paths;
    timeunit 1ns;
    timeprecision 1ps;

    import ssp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 64;   // quiet cycles before a register write
    localparam int HOLD_CYCLES = 400;  // long receiver hold-off

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    in_t             item = '0;
    logic            push = 1'b0;
    logic            full;
    out_t            result;
    logic            empty;
    logic            pop = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic            cfg_index = CFG_VERTEX_COUNT;
    logic [NV_W-1:0] cfg_data = '0;

    single_source_shortest_paths i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .result    (result),
        .empty     (empty),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the edge store and registers
    // ------------------------------------------------------------------
    logic [VTX_W-1:0]        edge_tail [MAX_EDGES];
    logic [VTX_W-1:0]        edge_head [MAX_EDGES];
    logic signed [WGT_W-1:0] edge_cost [MAX_EDGES];
    int                      stored_edges = 0;
    bit                      store_overflowed = 1'b0;
    int                      vertex_count_reg = MAX_VERTICES;
    int                      source_reg = 0;

    out_t                    expected_beats [$];
    int                      errors = 0;
    int                      cycles = 0;
    int                      hold_req = 0;
    int                      burst_left = 0;

    function automatic out_t make_beat(status_t st, int vid, bit rch, longint len, bit last);
        out_t o;
        o.status      = st;
        o.vertex_id   = VTX_W'(vid);
        o.reachable   = rch;
        o.path_length = DIST_W'(len);
        o.last_result = last;
        return o;
    endfunction

    function automatic void queue_beat(out_t b);
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // Bellman-Ford over the stored edges; appends the run's beats
    function automatic void solve_graph();
        longint dist_tab [MAX_VERTICES];
        bit     known [MAX_VERTICES];
        longint cand;
        int     n;
        int     a;
        int     b;
        bit     cycle;
        n = vertex_count_reg;
        cycle = 1'b0;
        if (n < 1) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            dist_tab[i] = 0;
            known[i] = 1'b0;
        end
        if (source_reg < n) known[source_reg] = 1'b1;
        for (int p = 0; p + 1 < n; p++)
        begin
            for (int j = 0; j < stored_edges; j++)
            begin
                a = edge_tail[j];
                b = edge_head[j];
                if (a >= n || b >= n || !known[a]) continue;
                cand = dist_tab[a] + longint'(edge_cost[j]);
                // relaxed distances clamp to the 24-bit signed range
                if (cand > 64'sd8388607) cand = 64'sd8388607;
                if (cand < -64'sd8388608) cand = -64'sd8388608;
                if (!known[b] || cand < dist_tab[b])
                begin
                    dist_tab[b] = cand;
                    known[b] = 1'b1;
                end
            end
        end
        // cycle check compares unclamped
        for (int j = 0; j < stored_edges && !cycle; j++)
        begin
            a = edge_tail[j];
            b = edge_head[j];
            if (a >= n || b >= n || !known[a]) continue;
            if (!known[b] || dist_tab[a] + longint'(edge_cost[j]) < dist_tab[b]) cycle = 1'b1;
        end
        if (cycle)
        begin
            queue_beat(make_beat(ST_CYCLE, 0, 1'b0, 0, 1'b1));
        end
        else
        begin
            for (int i = 0; i < n; i++)
                queue_beat(make_beat(ST_DIST, i, known[i],
                                     known[i] ? dist_tab[i] : 0, i + 1 == n));
        end
    endfunction

    function automatic void predict_edge(in_t it);
        if (stored_edges < MAX_EDGES)
        begin
            edge_tail[stored_edges] = it.tail_vertex;
            edge_head[stored_edges] = it.head_vertex;
            edge_cost[stored_edges] = it.edge_weight;
            stored_edges++;
        end
        else
        begin
            store_overflowed = 1'b1;
        end
        if (!it.last_edge) return;
        if (store_overflowed)
            queue_beat(make_beat(ST_OVFL, 0, 1'b0, 0, 1'b1));
        else
            solve_graph();
        // next beat opens a fresh graph
        stored_edges = 0;
        store_overflowed = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offers one beat and waits for it to be taken. push stays high between
    // beats of a burst; it drops for a nonzero gap between bursts and in drain().
    task automatic send_edge(in_t it, bit typed = 1'b0, out_t want = '0);
        int gap;
        int mark;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        mark = expected_beats.size();
        predict_edge(it);
        if (typed)
        begin
            // hand-written expectation stands in for the predicted one
            while (expected_beats.size() > mark) void'(expected_beats.pop_back());
            queue_beat(want);
        end
    endtask

    function automatic in_t make_edge(int t, int h, int w, bit last);
        in_t it;
        it.tail_vertex = VTX_W'(t);
        it.head_vertex = VTX_W'(h);
        it.edge_weight = WGT_W'(w);
        it.last_edge   = last;
        return it;
    endfunction

    // Stop offering, let every expected beat drain, then let the engine settle
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= NV_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_VERTEX_COUNT) vertex_count_reg = value;
        else source_reg = value;
    endtask

    task automatic set_graph_regs(int vc, int src);
        drain();
        write_reg(CFG_VERTEX_COUNT, vc);
        @(posedge clk);
        write_reg(CFG_SOURCE_VERTEX, src);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit   set_regs;
        int   vc;
        int   src;
        in_t  it;
        bit   typed;
        out_t want;
    } row_t;

    row_t directed_rows [$];

    function automatic void add_row(bit set_regs, int vc, int src, int t, int h, int w,
                                    bit last, bit typed = 1'b0, out_t want = '0);
        row_t r;
        r.set_regs = set_regs;
        r.vc = vc;
        r.src = src;
        r.it = make_edge(t, h, w, last);
        r.typed = typed;
        r.want = want;
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Result side: checker and stall pattern
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        int   hold_cnt;
        int   mode_cnt;
        int   stall_pct;
        out_t e;
        hold_cnt = 0;
        mode_cnt = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none actual %p",
                             $time, result);
                    errors++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    check_field("status", e.status, result.status);
                    check_field("vertex_id", e.vertex_id, result.vertex_id);
                    check_field("reachable", e.reachable, result.reachable);
                    check_field("path_length", e.path_length, result.path_length);
                    check_field("last_result", e.last_result, result.last_result);
                end
            end
            if (hold_req != 0)
            begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 0;
            end
            // stall density is redrawn whenever mode_cnt runs out, sometimes none at all
            if (mode_cnt == 0)
            begin
                mode_cnt = 64;
                stall_pct = 25 * $urandom_range(0, 3);
            end
            mode_cnt--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int   vc;
        int   src;
        int   ne;
        int   sent;
        int   t;
        int   h;
        int   w;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: 64 vertices from vertex 0, extreme vertex ids
        add_row(0, 0, 0, 0, 63, 32767, 1);
        // one vertex, negative self loop
        add_row(1, 1, 0, 0, 0, -32768, 1, 1, make_beat(ST_CYCLE, 0, 0, 0, 1));
        // three-vertex negative cycle through the source
        add_row(1, 3, 2, 2, 1, -5, 0);
        add_row(0, 0, 0, 1, 0, 7, 0);
        add_row(0, 0, 0, 0, 2, -3, 1);
        // vertex count zero acts as one; edge out of range is ignored
        add_row(1, 0, 0, 5, 5, 1, 1, 1, make_beat(ST_DIST, 0, 1, 0, 1));
        // count above the maximum acts as 64; source at the top
        add_row(1, 127, 63, 63, 0, -32768, 1);
        // source out of range: nothing reachable
        add_row(1, 4, 5, 0, 1, 1, 1);
        // long positive chain plus a head out of range
        add_row(1, 4, 0, 0, 1, 32767, 0);
        add_row(0, 0, 0, 1, 2, 32767, 0);
        add_row(0, 0, 0, 2, 3, 32767, 0);
        add_row(0, 0, 0, 3, 40, -32768, 1);
        // tight two-vertex negative loop deep enough to saturate
        add_row(1, 64, 0, 0, 1, -32768, 0);
        add_row(0, 0, 0, 1, 0, -32768, 0);
        add_row(0, 0, 0, 0, 1, -32768, 0);
        add_row(0, 0, 0, 1, 0, -32768, 0);
        add_row(0, 0, 0, 0, 1, -32768, 0);
        add_row(0, 0, 0, 1, 0, -32768, 1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_regs)
                set_graph_regs(directed_rows[i].vc, directed_rows[i].src);
            send_edge(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        end

        // random graphs, mostly small, registers changed about half the time
        sent = 0;
        while (sent < 50)
        begin
            if (sent == 0 || $urandom_range(0, 1) == 1)
            begin
                vc = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 8);
                src = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, vc - 1);
                set_graph_regs(vc, src);
            end
            ne = $urandom_range(1, 10);
            for (int j = 0; j < ne; j++)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    t = $urandom_range(0, 63);
                    h = $urandom_range(0, 63);
                end
                else
                begin
                    t = $urandom_range(0, vertex_count_reg > 64 ? 63 : vertex_count_reg - 1);
                    h = $urandom_range(0, vertex_count_reg > 64 ? 63 : vertex_count_reg - 1);
                end
                w = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 220) - 20;
                send_edge(make_edge(t, h, w, j == ne - 1));
                sent++;
            end
        end

        // pressure: results held off while several graphs keep coming
        set_graph_regs(4, 0);
        hold_req = 1;
        for (int g = 0; g < 4; g++)
            for (int j = 0; j < 8; j++)
                send_edge(make_edge($urandom_range(0, 3), $urandom_range(0, 3),
                                    $urandom_range(0, 100), j == 7));

        drain();
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
